// ===== rtl/core/csc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC sine/cosine package
// Shared types and constants for the rotation-mode CORDIC pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int DATA_W  = 32;   // datapath width, sums wrap here
   localparam int OUT_W   = 18;   // result field width
   localparam int COUNT_W = 5;    // iteration count register width
   localparam int ATAN_N  = 30;   // entries in the arctangent table

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // gain 0.6073 as a ratio
   localparam logic [63:0] GAIN_NUM = 64'd6073;
   localparam logic [63:0] GAIN_DEN = 64'd10000;

   // atan(2^-i) scaled by 2^30, truncated
   localparam logic [31:0] ATAN_Q30 [0:ATAN_N-1] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
      32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
      32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
      32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
      32'd31,        32'd15,        32'd7,         32'd3,         32'd1
   };

   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } vec_type;

endpackage
`default_nettype wire

// ===== rtl/core/csc_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One registered rotation by atan(2^-STEP); passes the vector unchanged when
// the step lies beyond the configured iteration count.
// ----------------------------------------------------------------------------
module csc_stage #(
   parameter int STEP          = 0,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             enable,
   input  wire logic             src_valid,
   input  wire csc_pkg::vec_type src_vec,
   output logic                  valid_ff,
   output csc_pkg::vec_type      vec_ff
);

   localparam logic [csc_pkg::DATA_W-1:0] ATAN_STEP =
      csc_pkg::DATA_W'(csc_pkg::ATAN_Q30[STEP] >> (30 - FRACTION_BITS));

   logic                         valid_in;
   csc_pkg::vec_type             vec_in;
   logic [csc_pkg::DATA_W-1:0]   x_shift;
   logic [csc_pkg::DATA_W-1:0]   y_shift;

   always_comb begin
      x_shift  = $signed(src_vec.x) >>> STEP;
      y_shift  = $signed(src_vec.y) >>> STEP;
      valid_in = src_valid;
      vec_in   = src_vec;
      if (enable) begin
         if (src_vec.z[csc_pkg::DATA_W-1]) begin
            vec_in.x = src_vec.x + y_shift;
            vec_in.y = src_vec.y - x_shift;
            vec_in.z = src_vec.z + ATAN_STEP;
         end else begin
            vec_in.x = src_vec.x - y_shift;
            vec_in.y = src_vec.y + x_shift;
            vec_in.z = src_vec.z - ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
      end
   end

`ifndef SYNTHESIS
   // hold the stage while the pipeline is frozen
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("stage valid moved while frozen");

   assert property (@(posedge clock) disable iff (reset)
      advance && src_valid |=> valid_ff)
      else $error("stage dropped an item");

   // a step past the count must leave the vector untouched
   assert property (@(posedge clock) disable iff (reset)
      advance && !enable |=> vec_ff == $past(src_vec))
      else $error("disabled step altered the vector");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/csc_gain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC gain correction
// Scales x and y by the CORDIC gain and registers the result fields.
// ----------------------------------------------------------------------------
module csc_gain #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            src_valid,
   input  wire csc_pkg::vec_type                src_vec,
   output logic                                 valid_ff,
   output logic signed [csc_pkg::OUT_W-1:0]     sine_ff,
   output logic signed [csc_pkg::OUT_W-1:0]     cosine_ff
);

   localparam int HALF = FRACTION_BITS / 2;
   localparam logic [63:0] GAIN_FULL =
      (csc_pkg::GAIN_NUM << FRACTION_BITS) / csc_pkg::GAIN_DEN;
   localparam logic [csc_pkg::OUT_W-1:0] GAIN_HALF =
      csc_pkg::OUT_W'(GAIN_FULL >> HALF);

   logic [csc_pkg::DATA_W-1:0]    x_shift;
   logic [csc_pkg::DATA_W-1:0]    y_shift;
   logic [csc_pkg::OUT_W-1:0]     x_prod;
   logic [csc_pkg::OUT_W-1:0]     y_prod;
   logic                          valid_in;
   logic [csc_pkg::OUT_W-1:0]     sine_in;
   logic [csc_pkg::OUT_W-1:0]     cosine_in;

   // only the low result bits are kept, so a narrow multiply suffices
   always_comb begin
      x_shift   = $signed(src_vec.x) >>> HALF;
      y_shift   = $signed(src_vec.y) >>> HALF;
      x_prod    = x_shift[csc_pkg::OUT_W-1:0] * GAIN_HALF;
      y_prod    = y_shift[csc_pkg::OUT_W-1:0] * GAIN_HALF;
      valid_in  = src_valid;
      sine_in   = y_prod;
      cosine_in = x_prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/cordic_sine_cosine_q16.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC sine/cosine generator
// Rotation-mode CORDIC with one pipeline stage per micro-rotation.
// ----------------------------------------------------------------------------
// Feed signed fixed-point angles (radians) on req_angle with req_valid; the
// item is taken at a clock edge where req_valid is high and req_stall is low.
// Sine and cosine come out on rsp_sine / rsp_cosine with rsp_valid, taken by
// the receiver when rsp_stall is low.
// The path holds one register per micro-rotation stage and one for the gain
// multiply. One angle enters every cycle while the output is not stalled, so
// throughput is one item per clock.
// While rsp_stall holds a valid result, the whole pipeline freezes and
// req_stall rises; nothing is lost or repeated.
// csr_iteration_count sets how many rotations apply (values above MAX_STEPS
// act as MAX_STEPS); write it only while the pipeline is empty. csr_ready is
// always high. Reset empties the pipeline and sets the count to 16.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_q16 #(
   parameter int MAX_STEPS     = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [csc_pkg::DATA_W-1:0]   req_angle,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [csc_pkg::OUT_W-1:0]         rsp_sine,
   output logic signed [csc_pkg::OUT_W-1:0]         rsp_cosine,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [csc_pkg::COUNT_W-1:0]         csr_iteration_count
);

   logic                           advance;
   logic [csc_pkg::COUNT_W-1:0]    count_ff;
   logic [csc_pkg::COUNT_W-1:0]    count_in;
   logic                           stage_valid [0:MAX_STEPS];
   csc_pkg::vec_type               stage_vec   [0:MAX_STEPS];

   // freeze everything while a finished item waits on the receiver
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      if (csr_valid) begin
         count_in = csr_iteration_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= csc_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stage_valid[0]   = req_valid;
   assign stage_vec[0].x   = csc_pkg::DATA_W'(1) << FRACTION_BITS;
   assign stage_vec[0].y   = '0;
   assign stage_vec[0].z   = req_angle;

   for (genvar s = 0; s < MAX_STEPS; s++) begin : g_step
      csc_stage #(
         .STEP          (s),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .enable    (count_ff > csc_pkg::COUNT_W'(s)),
         .src_valid (stage_valid[s]),
         .src_vec   (stage_vec[s]),
         .valid_ff  (stage_valid[s+1]),
         .vec_ff    (stage_vec[s+1])
      );
   end

   csc_gain #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .src_valid (stage_valid[MAX_STEPS]),
      .src_vec   (stage_vec[MAX_STEPS]),
      .valid_ff  (rsp_valid),
      .sine_ff   (rsp_sine),
      .cosine_ff (rsp_cosine)
   );

endmodule
`default_nettype wire
